/* rtl/rgb_to_color_index_unit_defines.svh */
// Assertion macros shared by the verification side of the color index unit.
// No dependencies; included by the checker file.
`ifndef RGB_TO_COLOR_INDEX_UNIT_DEFINES_SVH
`define RGB_TO_COLOR_INDEX_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is held
`define RCI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define RCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rci_pkg.sv */
// Shared types and constants of the RGB to color index unit.
// No dependencies.
package rci_pkg;

	typedef logic [7:0]  rci_chan_t;
	typedef logic [7:0]  rci_index_t;
	typedef logic [47:0] rci_lanes_t;
	typedef logic [63:0] rci_word_t;
	typedef logic [5:0]  rci_addr_t;

	// Register indexes, one per 8-byte slot
	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_CWEIGHT = 3'd1,
		REG_CMASK   = 3'd2,
		REG_AWEIGHT = 3'd3,
		REG_BASE    = 3'd4,
		REG_LIMIT   = 3'd5,
		REG_SCALE   = 3'd6
	} rci_reg_t;

	localparam rci_index_t INDEX_MAX   = 8'd255;
	localparam rci_index_t LIMIT_RESET = 8'd255;

endpackage

/* rtl/rci_stream_if.sv */
// Valid/ready stream interfaces for pixel beats and index beats.
// Depends on rci_pkg.
interface rci_pix_if;
	import rci_pkg::*;
	logic      valid;
	logic      ready;
	rci_chan_t red;
	rci_chan_t green;
	rci_chan_t blue;
	logic      line_end_in;

	modport source (output valid, red, green, blue, line_end_in, input ready);
	modport sink (input valid, red, green, blue, line_end_in, output ready);
endinterface

interface rci_idx_if;
	import rci_pkg::*;
	logic       valid;
	logic       ready;
	rci_index_t color_index;
	logic       line_end_out;

	modport source (output valid, color_index, line_end_out, input ready);
	modport sink (input valid, color_index, line_end_out, output ready);
endinterface

/* rtl/rgb_to_color_index_unit.sv */
// Top level of the RGB to color index unit: APB registers and a four-stage pipeline.
// Depends on rci_pkg and the stream interfaces in rci_stream_if.sv.
//
// channel   direction  beat payload
// pixel     in         red, green, blue, line_end_in
// result    out        color_index, line_end_out
// apb       in/out     64-bit register writes and reads, 8-byte slots
//
// One pixel per clock unless a stall on result fills every stage back to the input.
// Latency is set by the range path: channel products, weighted sum, scale
// product, then base add and limit cap, one register stage each.
// Reset clears valid bits and loads register reset values; no clearing pass.
// A stall on result holds filled stages; empty stages keep accepting pixels.
module rgb_to_color_index_unit (
	input  logic              clk,
	input  logic              arst_n,
	rci_pix_if.sink           pixel,
	rci_idx_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  rci_pkg::rci_addr_t paddr,
	input  rci_pkg::rci_word_t pwdata,
	output rci_pkg::rci_word_t prdata,
	output logic              pready
);
	import rci_pkg::*;

	// configuration registers
	logic       mode_q;
	rci_lanes_t cweight_q;
	rci_lanes_t cmask_q;
	rci_lanes_t aweight_q;
	rci_index_t base_q;
	rci_index_t limit_q;
	logic [15:0] scale_q;

	logic     wr_en;
	rci_reg_t wr_reg;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_reg = rci_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			cweight_q <= '0;
			cmask_q   <= '0;
			aweight_q <= '0;
			base_q    <= '0;
			limit_q   <= LIMIT_RESET;
			scale_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_reg)
				REG_MODE:    mode_q    <= pwdata[0];
				REG_CWEIGHT: cweight_q <= pwdata[47:0];
				REG_CMASK:   cmask_q   <= pwdata[47:0];
				REG_AWEIGHT: aweight_q <= pwdata[47:0];
				REG_BASE:    base_q    <= pwdata[7:0];
				REG_LIMIT:   limit_q   <= pwdata[7:0];
				REG_SCALE:   scale_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (wr_reg)
			REG_MODE:    prdata = {63'd0, mode_q};
			REG_CWEIGHT: prdata = {16'd0, cweight_q};
			REG_CMASK:   prdata = {16'd0, cmask_q};
			REG_AWEIGHT: prdata = {16'd0, aweight_q};
			REG_BASE:    prdata = {56'd0, base_q};
			REG_LIMIT:   prdata = {56'd0, limit_q};
			REG_SCALE:   prdata = {48'd0, scale_q};
			default:     prdata = '0;
		endcase
	end

	// stage advance: a stage loads when it is empty or its contents move on
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !v_s4 || result.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pixel.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: channel times weight, both modes
	logic [23:0] cprod_s1 [3];
	logic [23:0] aprod_s1 [3];
	logic        le_s1;
	rci_chan_t   ch [3];

	assign ch[0] = pixel.red;
	assign ch[1] = pixel.green;
	assign ch[2] = pixel.blue;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 3; k++) begin
				cprod_s1[k] <= cweight_q[16*k +: 16] * ch[k];
				aprod_s1[k] <= aweight_q[16*k +: 16] * ch[k];
			end
			le_s1 <= pixel.line_end_in;
		end
	end

	// stage 2: masked component sum with saturation; range weighted sum
	logic [17:0] csum;
	rci_index_t  cidx_s2;
	logic [25:0] acc_s2;
	logic        le_s2;

	assign csum = 18'(cprod_s1[0][23:8] & cmask_q[15:0])
		+ 18'(cprod_s1[1][23:8] & cmask_q[31:16])
		+ 18'(cprod_s1[2][23:8] & cmask_q[47:32]);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cidx_s2 <= (csum > 18'(INDEX_MAX)) ? INDEX_MAX : csum[7:0];
			acc_s2  <= 26'(aprod_s1[0]) + 26'(aprod_s1[1]) + 26'(aprod_s1[2]);
			le_s2   <= le_s1;
		end
	end

	// stage 3: scale product, drop 23 fraction bits
	logic [41:0] sprod;
	logic [18:0] scaled_s3;
	rci_index_t  cidx_s3;
	logic        le_s3;

	assign sprod = acc_s2 * scale_q;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			scaled_s3 <= sprod[41:23];
			cidx_s3   <= cidx_s2;
			le_s3     <= le_s2;
		end
	end

	// stage 4: add base, cap at limit; the cap keeps it within 0..255
	logic [19:0] ridx;
	rci_index_t  rcap;
	rci_index_t  idx_s4;
	logic        le_s4;

	assign ridx = 20'(base_q) + 20'(scaled_s3);
	assign rcap = (ridx > 20'(limit_q)) ? limit_q : ridx[7:0];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			idx_s4 <= mode_q ? rcap : cidx_s3;
			le_s4  <= le_s3;
		end
	end

	assign result.valid        = v_s4;
	assign result.color_index  = idx_s4;
	assign result.line_end_out = le_s4;

endmodule

/* rtl/rci_checker.sv */
// Port-level checker for the RGB to color index unit, bound to the top level.
// Depends on rgb_to_color_index_unit_defines.svh and rci_pkg.
`include "rgb_to_color_index_unit_defines.svh"

module rci_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input rci_pkg::rci_addr_t paddr,
	input rci_pkg::rci_word_t pwdata,
	input rci_pkg::rci_word_t prdata
);
	import rci_pkg::*;

	logic mode_wr;
	assign mode_wr = psel && penable && pwrite && (paddr[5:3] == REG_MODE);

	// a pending result beat is never dropped
	`RCI_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result beat dropped")

	// a free output means the whole pipe can move, so pixels are taken
	`RCI_ASSERT(a_ready_chain, clk, arst_n, out_ready |-> in_ready, "pixel stalled with free output")

	// mode register reads back what was written to it
	`RCI_ASSERT(a_mode_rb, clk, arst_n, $past(mode_wr) && !mode_wr && (paddr[5:3] == REG_MODE) |-> (prdata[0] == $past(pwdata[0])) && (prdata[63:1] == 63'd0), "mode readback mismatch")

	// no result beat comes out of reset
	`RCI_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind rgb_to_color_index_unit rci_checker u_rci_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
